FILE: rtl/knn_pkg.sv
// Shared types and constants for the k-nearest-neighbor classifier.
package knn_pkg;

    localparam int NUM_TRAIN_DEF    = 1024;
    localparam int MAX_FEATURES_DEF = 1024;
    localparam int MAX_K_DEF        = 16;
    localparam int NUM_CLASSES_DEF  = 16;

    localparam int DIST_W   = 27;
    localparam int FEAT_W   = 8;
    localparam int LABEL_W  = 4;
    localparam int KREG_W   = 5;
    localparam int FCNT_W   = 11;
    localparam int CFG_W    = 11;
    localparam int VOTES_W  = 5;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [KREG_W-1:0] K_RESET  = KREG_W'(3);
    localparam logic [FCNT_W-1:0] FCNT_RESET = FCNT_W'(784);

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_TRAIN = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic {
        REG_K_NEIGHBORS   = 1'b0,
        REG_FEATURE_COUNT = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_INSERT,
        S_VOTE,
        S_DONE
    } state_t;

    // One distance finished by the scanner, handed to the ranking unit.
    typedef struct packed {
        logic                valid;
        logic [DIST_W-1:0]   sqdist;
        logic [LABEL_W-1:0]  label;
    } cand_t;

endpackage

FILE: rtl/knn_store.sv
// Training feature/label memories and query buffer with synchronous reads.
module knn_store #(
    parameter int NUM_TRAIN    = knn_pkg::NUM_TRAIN_DEF,
    parameter int MAX_FEATURES = knn_pkg::MAX_FEATURES_DEF,
    parameter int RW           = (NUM_TRAIN > 1) ? $clog2(NUM_TRAIN) : 1,
    parameter int FW           = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
    input  logic                          clk,
    input  logic                          tr_we,
    input  logic [RW-1:0]                 tr_row,
    input  logic [FW-1:0]                 tr_col,
    input  logic [knn_pkg::FEAT_W-1:0]    tr_data,
    input  logic                          lb_we,
    input  logic [knn_pkg::LABEL_W-1:0]   lb_data,
    input  logic                          q_we,
    input  logic [FW-1:0]                 q_col,
    input  logic [knn_pkg::FEAT_W-1:0]    q_data,
    input  logic [RW-1:0]                 rd_row,
    input  logic [FW-1:0]                 rd_col,
    output logic [knn_pkg::FEAT_W-1:0]    rd_train,
    output logic [knn_pkg::FEAT_W-1:0]    rd_query,
    output logic [knn_pkg::LABEL_W-1:0]   rd_label
);
    import knn_pkg::*;

    logic [FEAT_W-1:0]  feat_mem [NUM_TRAIN*MAX_FEATURES];
    logic [LABEL_W-1:0] label_mem [NUM_TRAIN];
    logic [FEAT_W-1:0]  query_mem [MAX_FEATURES];

    localparam int AW = RW + FW;

    function automatic logic [AW-1:0] flat(input logic [RW-1:0] r, input logic [FW-1:0] c);
        flat = AW'(r) * AW'(MAX_FEATURES) + AW'(c);
    endfunction

    always_ff @(posedge clk)
    begin
        if (tr_we)
        begin
            feat_mem[flat(tr_row, tr_col)] <= tr_data;
        end
        rd_train <= feat_mem[flat(rd_row, rd_col)];
    end

    always_ff @(posedge clk)
    begin
        if (lb_we)
        begin
            label_mem[tr_row] <= lb_data;
        end
        rd_label <= label_mem[rd_row];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            query_mem[q_col] <= q_data;
        end
        rd_query <= query_mem[rd_col];
    end

endmodule

FILE: rtl/knn_rank.sv
// Sorted k-best list: one candidate insertion, then a serial vote count.
module knn_rank #(
    parameter int MAX_K       = knn_pkg::MAX_K_DEF,
    parameter int NUM_CLASSES = knn_pkg::NUM_CLASSES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  knn_pkg::cand_t                cand,
    input  logic [$clog2(MAX_K+1)-1:0]    k_eff,
    input  logic                          vote_start,
    output logic                          vote_done,
    output logic [knn_pkg::LABEL_W-1:0]   best_label,
    output logic [knn_pkg::VOTES_W-1:0]   best_votes
);
    import knn_pkg::*;

    localparam int KW = $clog2(MAX_K + 1);
    localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int VW = $clog2(MAX_K + 1);
    localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    logic [DIST_W-1:0]  dist_reg  [MAX_K];
    logic [LABEL_W-1:0] lab_reg   [MAX_K];
    logic [KW-1:0]      have_reg, have_next;

    // Parallel insertion: every slot compares against its own entry.
    logic [MAX_K-1:0] gt;
    always_comb
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            gt[i] = (KW'(i) < have_reg) ? (dist_reg[i] > cand.sqdist) : 1'b1;
        end
    end

    logic accept;
    assign accept = cand.valid && ((have_reg < k_eff) || gt[IW'(k_eff - KW'(1))]);
    assign have_next = (have_reg < k_eff) ? have_reg + KW'(1) : have_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_K; i++)
            begin
                if (gt[i])
                begin
                    if (i == 0 || !gt[(i > 0) ? i - 1 : 0])
                    begin
                        dist_reg[i] <= cand.sqdist;
                        lab_reg[i]  <= cand.label;
                    end
                    else
                    begin
                        dist_reg[i] <= dist_reg[(i > 0) ? i - 1 : 0];
                        lab_reg[i]  <= lab_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end
        end
    end

    // Vote: walk classes; for each class count matches over the list (parallel compare).
    logic             voting_reg;
    logic [CW:0]      cls_reg;
    logic [VW-1:0]    cnt;
    logic [CW-1:0]    bl_reg;
    logic [VW-1:0]    bv_reg;
    logic             done_reg;

    always_comb
    begin
        cnt = '0;
        for (int i = 0; i < MAX_K; i++)
        begin
            if ((KW'(i) < have_reg) && (CW'(lab_reg[i]) == cls_reg[CW-1:0]))
            begin
                cnt = cnt + VW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg   <= '0;
            voting_reg <= 1'b0;
            cls_reg    <= '0;
            bl_reg     <= '0;
            bv_reg     <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (clear)
            begin
                have_reg <= '0;
            end
            else if (accept)
            begin
                have_reg <= have_next;
            end
            if (vote_start)
            begin
                voting_reg <= 1'b1;
                cls_reg    <= '0;
                bl_reg     <= '0;
                bv_reg     <= '0;
            end
            else if (voting_reg)
            begin
                if (cnt > bv_reg)
                begin
                    bv_reg <= cnt;
                    bl_reg <= cls_reg[CW-1:0];
                end
                if (cls_reg == (CW+1)'(NUM_CLASSES - 1))
                begin
                    voting_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
                cls_reg <= cls_reg + (CW+1)'(1);
            end
        end
    end

    assign vote_done  = done_reg;
    assign best_label = LABEL_W'(bl_reg);
    assign best_votes = VOTES_W'(bv_reg);

endmodule

FILE: rtl/knn_majority_classifier.sv
// Top level: input sequencing, distance scan over the training memory, result.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-------------------------
//  input   | action, feature_value, class_label        | start & !busy
//  result  | winner_label, found, winning_votes        | done strobe, one cycle
//  config  | cfg_we, cfg_index, cfg_wdata              | cfg_we, no wait
//
// A training or query feature that is not a query end leaves busy low.
// A query end scans every stored vector, one feature per cycle from the
// training memory port, then drains, inserts and votes while busy; done
// rises as busy falls, also on an empty store, where found stays low.
// Reset empties the store; done pulses once and cannot be stalled.
module knn_majority_classifier #(
    parameter int NUM_TRAIN    = knn_pkg::NUM_TRAIN_DEF,
    parameter int MAX_FEATURES = knn_pkg::MAX_FEATURES_DEF,
    parameter int MAX_K        = knn_pkg::MAX_K_DEF,
    parameter int NUM_CLASSES  = knn_pkg::NUM_CLASSES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    action,
    input  logic [7:0]                    feature_value,
    input  logic [3:0]                    class_label,
    output logic                          done,
    output logic [3:0]                    winner_label,
    output logic                          found,
    output logic [4:0]                    winning_votes,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [knn_pkg::CFG_W-1:0]     cfg_wdata
);
    import knn_pkg::*;

    localparam int RW = (NUM_TRAIN > 1) ? $clog2(NUM_TRAIN) : 1;
    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CNTW = $clog2(NUM_TRAIN + 1);
    localparam int KW = $clog2(MAX_K + 1);
    localparam int NW = $clog2(MAX_FEATURES + 1);

    logic [KREG_W-1:0] k_reg;
    logic [FCNT_W-1:0] fc_reg;
    logic [CNTW-1:0]   count_reg, count_next;
    logic [FW-1:0]     pos_reg, pos_next;
    action_t           kind_reg, kind_next;
    state_t            state_reg, state_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [FW-1:0]     col_reg, col_next;
    logic              rd_v_reg, rd_last_reg;
    logic [DIST_W-1:0] acc_reg;
    cand_t             cand_reg;
    logic              done_reg;
    logic [3:0]        pl_reg;
    logic              found_reg;
    logic [4:0]        wv_reg;

    // Effective register values.
    logic [NW-1:0] n_eff;
    logic [KW-1:0] k_eff;
    always_comb
    begin
        if (fc_reg == '0)
            n_eff = NW'(1);
        else if (32'(fc_reg) > MAX_FEATURES)
            n_eff = NW'(MAX_FEATURES);
        else
            n_eff = NW'(fc_reg);
        if (k_reg == '0)
            k_eff = KW'(1);
        else if (32'(k_reg) > MAX_K)
            k_eff = KW'(MAX_K);
        else
            k_eff = KW'(k_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg  <= K_RESET;
            fc_reg <= FCNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_K_NEIGHBORS:   k_reg  <= KREG_W'(cfg_wdata);
                REG_FEATURE_COUNT: fc_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input item decode.
    logic acc_in;
    action_t act;
    logic [FW-1:0] epos;
    logic last;
    logic tr_we, lb_we, q_we;
    logic [LABEL_W-1:0] lab_sat;
    assign acc_in = start && !busy;
    assign act = action_t'(action);

    always_comb
    begin
        epos = (kind_reg != act) ? '0 : pos_reg;
        if (NW'(epos) >= n_eff)
            epos = FW'(n_eff - NW'(1));
        last = (NW'(epos) + NW'(1) >= n_eff);
        lab_sat = (32'(class_label) >= NUM_CLASSES) ? LABEL_W'(NUM_CLASSES - 1) : class_label;
        tr_we = acc_in && act == ACT_TRAIN && 32'(count_reg) < NUM_TRAIN;
        lb_we = tr_we && last;
        q_we  = acc_in && act == ACT_QUERY;
        count_next = count_reg;
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        if (acc_in)
        begin
            unique case (act)
                ACT_CLEAR:
                begin
                    count_next = '0;
                    pos_next   = '0;
                    kind_next  = ACT_NONE;
                end
                ACT_TRAIN, ACT_QUERY:
                begin
                    if (last)
                    begin
                        pos_next  = '0;
                        kind_next = ACT_NONE;
                    end
                    else
                    begin
                        pos_next  = epos + FW'(1);
                        kind_next = act;
                    end
                    if (lb_we)
                        count_next = count_reg + CNTW'(1);
                end
                default: ;
            endcase
        end
    end

    // Scan sequencer.
    logic rd_last;
    logic vote_start, vote_done;
    logic [LABEL_W-1:0] best_label;
    logic [VOTES_W-1:0] best_votes;
    logic rank_clear;

    assign rd_last = (NW'(col_reg) + NW'(1) >= n_eff);

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        vote_start = 1'b0;
        rank_clear = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_we && last)
                begin
                    rank_clear = 1'b1;
                    row_next   = '0;
                    col_next   = '0;
                    state_next = (count_reg == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_last)
                begin
                    col_next = '0;
                    if (CNTW'(row_reg) + CNTW'(1) >= count_reg)
                        state_next = S_DRAIN;
                    else
                        row_next = row_reg + RW'(1);
                end
                else
                begin
                    col_next = col_reg + FW'(1);
                end
            end
            S_DRAIN:
            begin
                if (!rd_v_reg)
                    state_next = S_INSERT;
            end
            S_INSERT:
            begin
                if (!cand_reg.valid)
                begin
                    vote_start = 1'b1;
                    state_next = S_VOTE;
                end
            end
            S_VOTE:
            begin
                if (vote_done)
                    state_next = S_IDLE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    logic [FEAT_W-1:0]   rd_train, rd_query;
    logic [LABEL_W-1:0]  rd_label;
    logic [FEAT_W-1:0]   adiff;
    logic [2*FEAT_W-1:0] prod;
    logic [DIST_W-1:0]   sq;
    assign adiff = (rd_query >= rd_train) ? rd_query - rd_train : rd_train - rd_query;
    assign prod  = adiff * adiff;
    assign sq    = DIST_W'(prod);

    knn_store #(
        .NUM_TRAIN    (NUM_TRAIN),
        .MAX_FEATURES (MAX_FEATURES),
        .RW           (RW),
        .FW           (FW)
    ) u_store (
        .clk      (clk),
        .tr_we    (tr_we),
        .tr_row   (RW'(count_reg)),
        .tr_col   (epos),
        .tr_data  (feature_value),
        .lb_we    (lb_we),
        .lb_data  (lab_sat),
        .q_we     (q_we),
        .q_col    (epos),
        .q_data   (feature_value),
        .rd_row   (row_reg),
        .rd_col   (col_reg),
        .rd_train (rd_train),
        .rd_query (rd_query),
        .rd_label (rd_label)
    );

    knn_rank #(
        .MAX_K       (MAX_K),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_rank (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (rank_clear),
        .cand       (cand_reg),
        .k_eff      (k_eff),
        .vote_start (vote_start),
        .vote_done  (vote_done),
        .best_label (best_label),
        .best_votes (best_votes)
    );

    // Accumulate squared differences; a row's sum goes out on its last feature.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pos_reg     <= '0;
            kind_reg    <= ACT_NONE;
            row_reg     <= '0;
            col_reg     <= '0;
            rd_v_reg    <= 1'b0;
            rd_last_reg <= 1'b0;
            acc_reg     <= '0;
            cand_reg    <= '0;
            done_reg    <= 1'b0;
            pl_reg      <= '0;
            found_reg   <= 1'b0;
            wv_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            kind_reg    <= kind_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            rd_v_reg    <= (state_reg == S_SCAN);
            rd_last_reg <= rd_last;
            cand_reg.valid <= 1'b0;
            if (rd_v_reg)
            begin
                if (rd_last_reg)
                begin
                    cand_reg.valid  <= 1'b1;
                    cand_reg.sqdist <= acc_reg + sq;
                    cand_reg.label  <= rd_label;
                    acc_reg         <= '0;
                end
                else
                begin
                    acc_reg <= acc_reg + sq;
                end
            end
            done_reg <= 1'b0;
            if (state_reg == S_DONE)
            begin
                done_reg  <= 1'b1;
                pl_reg    <= '0;
                found_reg <= 1'b0;
                wv_reg    <= '0;
            end
            else if (state_reg == S_VOTE && vote_done)
            begin
                done_reg  <= 1'b1;
                pl_reg    <= best_label;
                found_reg <= 1'b1;
                wv_reg    <= best_votes;
            end
        end
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign winner_label    = pl_reg;
    assign found           = found_reg;
    assign winning_votes   = wv_reg;

endmodule
